// ===== rtl/erq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the editable repeat command queue.
// No dependencies; imported by erq_mem, editable_repeat_command_queue and tb_top.
package erq_pkg;

    localparam int CAPACITY    = 64;
    localparam int MAX_REPEATS = 255;
    localparam int CMD_W       = 8;
    localparam int AW          = $clog2(CAPACITY);
    localparam int LW          = 7;
    localparam int RW          = 8;

    // Operation codes carried in the kind field.
    localparam logic [3:0] KIND_APPEND  = 4'd0;
    localparam logic [3:0] KIND_INSERT  = 4'd1;
    localparam logic [3:0] KIND_REMOVE  = 4'd2;
    localparam logic [3:0] KIND_MOVE    = 4'd3;
    localparam logic [3:0] KIND_SETREP  = 4'd4;
    localparam logic [3:0] KIND_CLEAR   = 4'd5;
    localparam logic [3:0] KIND_RESETPB = 4'd6;
    localparam logic [3:0] KIND_NEXT    = 4'd7;
    localparam logic [3:0] KIND_START   = 4'd8;
    localparam logic [3:0] KIND_STOP    = 4'd9;
    localparam logic [3:0] KIND_READ    = 4'd10;

    typedef struct packed {
        logic             done;
        logic [RW-1:0]    rep;
        logic [CMD_W-1:0] cmd;
    } entry_t;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        entry_t        wdata;
        logic          re;
        logic [AW-1:0] raddr;
    } mem_req_t;

endpackage

// ===== rtl/editable_repeat_command_queue.sv =====
`timescale 1ns / 1ps
// Top level: command list sequencer around the entry store.
// Depends on erq_pkg and erq_mem.
//
// Channel | Dir | tdata fields (low bit up)
// s_      | in  | kind[3:0] position[10:4] target_position[17:11] command_code[25:18]
//         |     | repeat_request[33:26]
// m_      | out | next_command[7:0] entry_command[15:8] entry_repeats[23:16]
//         |     | entry_done[24] entry_valid[25] accepted[26] list_length[33:27]
//         |     | cursor[40:34] repeat_position[48:41] playing[49] has_more[50]
//
// Every operation ends with a read of the cursor entry for the status, skipped when the
// cursor ends past the list end; read, next and set repeats also read the entry first.
// Insert, remove and move shift entries one at a time, each shift being a read and a
// write through the single store port pair; insert then writes the new entry, and move
// first reads the entry it moves and writes it in place after the shift. Reset clears
// all control state and the done flags at once. A beat is taken only while the
// sequencer is idle; a result that waits on m_tready holds the sequencer in its output
// state.
module editable_repeat_command_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // kind, position, target_position, command_code,
                                   // repeat_request
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // next_command, entry_command, entry_repeats,
                                   // entry_done, entry_valid, accepted, list_length,
                                   // cursor, repeat_position, playing, has_more
);
    import erq_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_EXEC     = 9'b000000010,
        S_HOLD     = 9'b000000100,
        S_SH_RD    = 9'b000001000,
        S_SH_WR    = 9'b000010000,
        S_PUT      = 9'b000100000,
        S_CUR      = 9'b001000000,
        S_CUR_WAIT = 9'b010000000,
        S_OUT      = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [3:0]       op_reg, op_next;
    logic [LW-1:0]    pos_reg, pos_next, tgt_reg, tgt_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic [RW-1:0]    req_reg, req_next;
    logic [LW-1:0]    idx_reg, idx_next, end_reg, end_next;
    logic             dec_reg, dec_next;
    entry_t           save_reg, save_next;
    logic [LW-1:0]    len_reg, len_next, cur_reg, cur_next;
    logic [RW-1:0]    ri_reg, ri_next;
    logic             play_reg, play_next;
    logic [CAPACITY-1:0] valid_reg;
    logic             clr_valid;
    logic             rvalid_reg;
    logic [CMD_W-1:0] nxt_reg, nxt_next, ecmd_reg, ecmd_next;
    logic [RW-1:0]    erep_reg, erep_next;
    logic             edone_reg, edone_next, evalid_reg, evalid_next;
    logic             acc_reg, acc_next, more_reg, more_next;
    logic [55:0]      m_tdata_reg, m_tdata_next;
    logic             m_tvalid_reg, m_tvalid_next;

    mem_req_t mem_req;
    entry_t   rdata;
    entry_t   rentry;
    logic [LW-1:0] src;
    logic [LW-1:0] ins_pos;
    logic [LW-1:0] rem_cur;
    logic [RW-1:0] clamp_rep;
    logic [RW-1:0] ri_inc;

    erq_mem u_mem (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (rdata)
    );

    // Read data with the done flag forced low for entries not yet written.
    always_comb begin
        rentry      = rdata;
        rentry.done = rdata.done & rvalid_reg;
    end

    assign src       = dec_reg ? (idx_reg - LW'(1)) : (idx_reg + LW'(1));
    assign ins_pos   = (pos_reg > len_reg) ? len_reg : pos_reg;
    assign clamp_rep = (req_reg == '0) ? RW'(1) :
                       ((req_reg > RW'(MAX_REPEATS)) ? RW'(MAX_REPEATS) : req_reg);
    assign ri_inc    = (ri_reg < {RW{1'b1}}) ? (ri_reg + RW'(1)) : ri_reg;

    // Cursor after a remove, before clamping to the new length.
    assign rem_cur = (pos_reg < cur_reg) ? (cur_reg - LW'(1)) : cur_reg;

    // Sequencer.
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        pos_next      = pos_reg;
        tgt_next      = tgt_reg;
        cmd_next      = cmd_reg;
        req_next      = req_reg;
        idx_next      = idx_reg;
        end_next      = end_reg;
        dec_next      = dec_reg;
        save_next     = save_reg;
        len_next      = len_reg;
        cur_next      = cur_reg;
        ri_next       = ri_reg;
        play_next     = play_reg;
        nxt_next      = nxt_reg;
        ecmd_next     = ecmd_reg;
        erep_next     = erep_reg;
        edone_next    = edone_reg;
        evalid_next   = evalid_reg;
        acc_next      = acc_reg;
        more_next     = more_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg;
        clr_valid     = 1'b0;
        mem_req       = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next     = s_tdata[3:0];
                    pos_next    = s_tdata[10:4];
                    tgt_next    = s_tdata[17:11];
                    cmd_next    = s_tdata[25:18];
                    req_next    = s_tdata[33:26];
                    nxt_next    = '0;
                    ecmd_next   = '0;
                    erep_next   = '0;
                    edone_next  = 1'b0;
                    evalid_next = 1'b0;
                    acc_next    = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_CUR;
                case (op_reg)
                    KIND_APPEND: begin
                        if (len_reg >= LW'(CAPACITY)) begin
                            acc_next = 1'b0;
                        end else begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = len_reg[AW-1:0];
                            mem_req.wdata = '{done: 1'b0, rep: RW'(1), cmd: cmd_reg};
                            len_next      = len_reg + LW'(1);
                        end
                    end
                    KIND_INSERT: begin
                        if (len_reg >= LW'(CAPACITY)) begin
                            acc_next = 1'b0;
                        end else begin
                            tgt_next  = ins_pos;
                            idx_next  = len_reg;
                            end_next  = ins_pos;
                            dec_next  = 1'b1;
                            save_next = '{done: 1'b0, rep: RW'(1), cmd: cmd_reg};
                            len_next  = len_reg + LW'(1);
                            if (ins_pos <= cur_reg && cur_reg < len_reg + LW'(1)) begin
                                cur_next = cur_reg + LW'(1);
                            end
                            state_next = (len_reg > ins_pos) ? S_SH_RD : S_PUT;
                        end
                    end
                    KIND_REMOVE: begin
                        if (pos_reg < len_reg) begin
                            idx_next = pos_reg;
                            end_next = len_reg - LW'(1);
                            dec_next = 1'b0;
                            len_next = len_reg - LW'(1);
                            if (pos_reg == cur_reg) begin
                                ri_next = '0;
                            end
                            cur_next = (rem_cur > len_reg - LW'(1)) ?
                                       (len_reg - LW'(1)) : rem_cur;
                            if (pos_reg + LW'(1) < len_reg) begin
                                state_next = S_SH_RD;
                            end
                        end
                    end
                    KIND_MOVE: begin
                        if (pos_reg < len_reg && tgt_reg < len_reg && pos_reg != tgt_reg) begin
                            mem_req.re    = 1'b1;
                            mem_req.raddr = pos_reg[AW-1:0];
                            if (pos_reg == cur_reg) begin
                                cur_next = tgt_reg;
                            end else if (pos_reg < cur_reg && tgt_reg >= cur_reg) begin
                                cur_next = cur_reg - LW'(1);
                            end else if (pos_reg > cur_reg && tgt_reg <= cur_reg) begin
                                cur_next = cur_reg + LW'(1);
                            end
                            state_next = S_HOLD;
                        end
                    end
                    KIND_SETREP, KIND_READ: begin
                        if (pos_reg < len_reg) begin
                            mem_req.re    = 1'b1;
                            mem_req.raddr = pos_reg[AW-1:0];
                            state_next    = S_HOLD;
                        end
                    end
                    KIND_NEXT: begin
                        if (play_reg && cur_reg < len_reg) begin
                            mem_req.re    = 1'b1;
                            mem_req.raddr = cur_reg[AW-1:0];
                            pos_next      = cur_reg;
                            state_next    = S_HOLD;
                        end
                    end
                    KIND_CLEAR: begin
                        len_next  = '0;
                        cur_next  = '0;
                        ri_next   = '0;
                        play_next = 1'b0;
                    end
                    KIND_RESETPB: begin
                        cur_next  = '0;
                        ri_next   = '0;
                        play_next = 1'b0;
                        clr_valid = 1'b1;
                    end
                    KIND_START: play_next = 1'b1;
                    KIND_STOP:  play_next = 1'b0;
                    default: ;
                endcase
            end
            S_HOLD: begin
                state_next = S_CUR;
                case (op_reg)
                    KIND_MOVE: begin
                        save_next  = rentry;
                        idx_next   = pos_reg;
                        end_next   = tgt_reg;
                        dec_next   = pos_reg > tgt_reg;
                        state_next = S_SH_RD;
                    end
                    KIND_SETREP: begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = pos_reg[AW-1:0];
                        mem_req.wdata = '{done: rentry.done, rep: clamp_rep, cmd: rentry.cmd};
                        if (pos_reg == cur_reg && ri_reg >= clamp_rep) begin
                            ri_next = '0;
                        end
                    end
                    KIND_NEXT: begin
                        nxt_next = rentry.cmd;
                        if (ri_inc >= rentry.rep) begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = pos_reg[AW-1:0];
                            mem_req.wdata = '{done: 1'b1, rep: rentry.rep, cmd: rentry.cmd};
                            ri_next       = '0;
                            cur_next      = cur_reg + LW'(1);
                        end else begin
                            ri_next = ri_inc;
                        end
                    end
                    default: begin
                        evalid_next = 1'b1;
                        ecmd_next   = rentry.cmd;
                        erep_next   = rentry.rep;
                        edone_next  = rentry.done;
                    end
                endcase
            end
            // Shift one entry: read the neighbor, then write it one place over.
            S_SH_RD: begin
                mem_req.re    = 1'b1;
                mem_req.raddr = src[AW-1:0];
                state_next    = S_SH_WR;
            end
            S_SH_WR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_reg[AW-1:0];
                mem_req.wdata = rentry;
                idx_next      = src;
                if (src == end_reg) begin
                    state_next = (op_reg == KIND_REMOVE) ? S_CUR : S_PUT;
                end else begin
                    state_next = S_SH_RD;
                end
            end
            S_PUT: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = tgt_reg[AW-1:0];
                mem_req.wdata = save_reg;
                state_next    = S_CUR;
            end
            // Fetch the cursor entry's repeat count for the status.
            S_CUR: begin
                if (cur_reg < len_reg) begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = cur_reg[AW-1:0];
                    state_next    = S_CUR_WAIT;
                end else begin
                    more_next  = 1'b0;
                    state_next = S_OUT;
                end
            end
            S_CUR_WAIT: begin
                more_next  = ri_reg < rentry.rep;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'b0, more_reg, play_reg, ri_reg, cur_reg, len_reg,
                                     acc_reg, evalid_reg, edone_reg, erep_reg, ecmd_reg,
                                     nxt_reg};
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            len_reg      <= '0;
            cur_reg      <= '0;
            ri_reg       <= '0;
            play_reg     <= 1'b0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            cur_reg      <= cur_next;
            ri_reg       <= ri_next;
            play_reg     <= play_next;
            m_tvalid_reg <= m_tvalid_next;
            if (clr_valid) begin
                valid_reg <= '0;
            end else if (mem_req.we) begin
                valid_reg[mem_req.waddr] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        pos_reg     <= pos_next;
        tgt_reg     <= tgt_next;
        cmd_reg     <= cmd_next;
        req_reg     <= req_next;
        idx_reg     <= idx_next;
        end_reg     <= end_next;
        dec_reg     <= dec_next;
        save_reg    <= save_next;
        nxt_reg     <= nxt_next;
        ecmd_reg    <= ecmd_next;
        erep_reg    <= erep_next;
        edone_reg   <= edone_next;
        evalid_reg  <= evalid_next;
        acc_reg     <= acc_next;
        more_reg    <= more_next;
        m_tdata_reg <= m_tdata_next;
        if (mem_req.re) begin
            rvalid_reg <= valid_reg[mem_req.raddr];
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_len_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(CAPACITY))
        else $error("list length above capacity");
    a_cur_len: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_reg <= len_reg)
        else $error("cursor beyond list end");
    a_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_req.we && mem_req.re && mem_req.waddr == mem_req.raddr))
        else $error("read and write of the same entry in one cycle");
`endif

endmodule

// ===== rtl/erq_mem.sv =====
`timescale 1ns / 1ps
// Entry store: one write port, one read port with registered read data.
// Depends on erq_pkg.
module erq_mem (
    input  logic              aclk,
    input  erq_pkg::mem_req_t req,
    output erq_pkg::entry_t   rdata
);
    import erq_pkg::*;

    entry_t mem [CAPACITY];

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the editable repeat command queue: a scoreboard
// class predicts every result beat, and plain tasks drive the input stream port.
// Depends on erq_pkg and the editable_repeat_command_queue RTL.
module tb_top;
    import erq_pkg::*;

    // Result beat as it sits in m_tdata[50:0].
    typedef struct packed {
        logic       has_more;
        logic       playing;
        logic [7:0] repeat_position;
        logic [6:0] cursor;
        logic [6:0] list_length;
        logic       accepted;
        logic       entry_valid;
        logic       entry_done;
        logic [7:0] entry_repeats;
        logic [7:0] entry_command;
        logic [7:0] next_command;
    } status_beat_t;

    // Tracks the command list and checks each result beat against it.
    class queue_scoreboard;
        logic [7:0]   cmd_mem[CAPACITY];
        logic [7:0]   rep_mem[CAPACITY];
        logic         done_mem[CAPACITY];
        int           len, cur, ridx;
        logic         play;
        int           errors;
        status_beat_t pending_beats[$];

        function new();
            len = 0; cur = 0; ridx = 0; play = 0; errors = 0;
            foreach (done_mem[i]) done_mem[i] = 0;
        endfunction

        function void put(int at, logic [7:0] c, logic [7:0] r, logic d);
            cmd_mem[at] = c; rep_mem[at] = r; done_mem[at] = d;
        endfunction

        // Apply one accepted beat to the list and queue the status it should produce.
        function void note_beat(logic [39:0] beat);
            logic [3:0]   kind;
            int           p, t, req, i;
            logic [7:0]   c, r;
            logic         d;
            status_beat_t e;
            kind = beat[3:0];
            p = beat[10:4];
            t = beat[17:11];
            c = beat[25:18];
            req = beat[33:26];
            e = '0;
            e.accepted = 1;
            case (kind)
                KIND_APPEND: begin
                    if (len >= CAPACITY) e.accepted = 0;
                    else begin
                        put(len, c, 8'd1, 0);
                        len++;
                    end
                end
                KIND_INSERT: begin
                    if (len >= CAPACITY) e.accepted = 0;
                    else begin
                        if (p > len) p = len;
                        for (i = len; i > p; i--)
                            put(i, cmd_mem[i-1], rep_mem[i-1], done_mem[i-1]);
                        put(p, c, 8'd1, 0);
                        len++;
                        if (p <= cur && cur < len) cur++;
                    end
                end
                KIND_REMOVE: begin
                    if (p < len) begin
                        for (i = p; i + 1 < len; i++)
                            put(i, cmd_mem[i+1], rep_mem[i+1], done_mem[i+1]);
                        len--;
                        if (p < cur) cur--;
                        else if (p == cur) ridx = 0;
                        if (cur > len) cur = len;
                    end
                end
                KIND_MOVE: begin
                    if (p < len && t < len && p != t) begin
                        c = cmd_mem[p]; r = rep_mem[p]; d = done_mem[p];
                        if (p < t)
                            for (i = p; i < t; i++)
                                put(i, cmd_mem[i+1], rep_mem[i+1], done_mem[i+1]);
                        else
                            for (i = p; i > t; i--)
                                put(i, cmd_mem[i-1], rep_mem[i-1], done_mem[i-1]);
                        put(t, c, r, d);
                        if (p == cur) cur = t;
                        else if (p < cur && t >= cur) cur--;
                        else if (p > cur && t <= cur) cur++;
                    end
                end
                KIND_SETREP: begin
                    if (p < len) begin
                        if (req < 1) req = 1;
                        if (req > MAX_REPEATS) req = MAX_REPEATS;
                        rep_mem[p] = req;
                        if (p == cur && ridx >= req) ridx = 0;
                    end
                end
                KIND_CLEAR: begin
                    len = 0; cur = 0; ridx = 0; play = 0;
                end
                KIND_RESETPB: begin
                    cur = 0; ridx = 0; play = 0;
                    foreach (done_mem[k]) done_mem[k] = 0;
                end
                KIND_NEXT: begin
                    if (play && cur < len) begin
                        e.next_command = cmd_mem[cur];
                        if (ridx < 255) ridx++;
                        if (ridx >= rep_mem[cur]) begin
                            done_mem[cur] = 1;
                            ridx = 0;
                            cur++;
                        end
                    end
                end
                KIND_START: play = 1;
                KIND_STOP:  play = 0;
                KIND_READ: begin
                    if (p < len) begin
                        e.entry_valid = 1;
                        e.entry_command = cmd_mem[p];
                        e.entry_repeats = rep_mem[p];
                        e.entry_done = done_mem[p];
                    end
                end
                default: ;
            endcase
            e.list_length = len;
            e.cursor = cur;
            e.repeat_position = ridx;
            e.playing = play;
            e.has_more = (cur < len) && (ridx < rep_mem[cur]);
            pending_beats = {pending_beats, e};
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %0t: %s got %0d expected %0d", $time, what, got, want);
            errors++;
        endtask

        // Compare one result beat with the oldest prediction.
        task check_beat(logic [55:0] data);
            status_beat_t g, e;
            g = data[50:0];
            if (pending_beats.size() == 0) begin
                report("unexpected result beat", 1, 0);
                return;
            end
            e = pending_beats.pop_front();
            if (g.next_command !== e.next_command)
                report("next_command", g.next_command, e.next_command);
            if (g.entry_command !== e.entry_command)
                report("entry_command", g.entry_command, e.entry_command);
            if (g.entry_repeats !== e.entry_repeats)
                report("entry_repeats", g.entry_repeats, e.entry_repeats);
            if (g.entry_done !== e.entry_done)
                report("entry_done", g.entry_done, e.entry_done);
            if (g.entry_valid !== e.entry_valid)
                report("entry_valid", g.entry_valid, e.entry_valid);
            if (g.accepted !== e.accepted)
                report("accepted", g.accepted, e.accepted);
            if (g.list_length !== e.list_length)
                report("list_length", g.list_length, e.list_length);
            if (g.cursor !== e.cursor)
                report("cursor", g.cursor, e.cursor);
            if (g.repeat_position !== e.repeat_position)
                report("repeat_position", g.repeat_position, e.repeat_position);
            if (g.playing !== e.playing)
                report("playing", g.playing, e.playing);
            if (g.has_more !== e.has_more)
                report("has_more", g.has_more, e.has_more);
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // kind, position, target_position, command_code, repeat_request
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // next_command .. has_more, see status_beat_t

    int              tx_idle;
    int              rx_idle;
    queue_scoreboard sb;

    editable_repeat_command_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 20 ns clock.
    initial aclk = 0;
    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    // Check accepted result beats, then pick the next ready level.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_beat(m_tdata);
        m_tready <= ($urandom_range(99) >= rx_idle);
    end

    // Send one beat with a random gap ahead of it; returns after the handshake.
    task send(logic [3:0] kind, int p, int t, int c, int req);
        while ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {6'd0, req[7:0], c[7:0], t[6:0], p[6:0], kind};
        do @(posedge aclk); while (!s_tready);
        sb.note_beat(s_tdata);
    endtask

    task drain();
        s_tvalid <= 0;
        while (sb.pending_beats.size() != 0) @(posedge aclk);
    endtask

    function logic [3:0] pick_kind();
        int r;
        r = $urandom_range(199);
        if (r < 60) return KIND_APPEND;
        if (r < 90) return KIND_INSERT;
        if (r < 104) return KIND_REMOVE;
        if (r < 118) return KIND_MOVE;
        if (r < 132) return KIND_SETREP;
        if (r < 133) return KIND_CLEAR;
        if (r < 135) return KIND_RESETPB;
        if (r < 170) return KIND_NEXT;
        if (r < 178) return KIND_START;
        if (r < 181) return KIND_STOP;
        if (r < 196) return KIND_READ;
        return 4'($urandom_range(11, 15));
    endfunction

    // Mostly positions near the list, sometimes anywhere in the field.
    function int pick_pos();
        if ($urandom_range(9) < 8) return $urandom_range(sb.len + 1);
        return $urandom_range(127);
    endfunction

    function int pick_req();
        if ($urandom_range(3) != 0) return $urandom_range(4);
        return $urandom_range(255);
    endfunction

    // Random phase of n beats.
    task random_phase(int n);
        for (int i = 0; i < n; i++)
            send(pick_kind(), pick_pos(), pick_pos(), $urandom_range(255), pick_req());
    endtask

    initial begin
        sb = new();
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        tx_idle = 29;
        rx_idle = 49;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: empty list, edge positions, clamping and cursor tracking.
        send(KIND_NEXT, 0, 0, 0, 0);
        send(KIND_READ, 0, 0, 0, 0);
        send(KIND_REMOVE, 0, 0, 0, 0);
        send(KIND_APPEND, 0, 0, 255, 0);
        send(KIND_APPEND, 0, 0, 0, 255);
        send(KIND_INSERT, 127, 0, 8'h5a, 0);
        send(KIND_INSERT, 0, 0, 8'ha5, 0);
        send(KIND_SETREP, 0, 0, 0, 0);
        send(KIND_SETREP, 1, 0, 0, 255);
        send(KIND_SETREP, 127, 0, 0, 3);
        send(KIND_START, 0, 0, 0, 0);
        send(KIND_NEXT, 0, 0, 0, 0);
        send(KIND_NEXT, 0, 0, 0, 0);
        send(KIND_MOVE, 1, 3, 0, 0);
        send(KIND_MOVE, 2, 2, 0, 0);
        send(KIND_MOVE, 0, 127, 0, 0);
        send(KIND_REMOVE, 1, 0, 0, 0);
        send(KIND_READ, 127, 0, 0, 0);
        send(KIND_READ, 0, 0, 0, 0);
        send(KIND_STOP, 0, 0, 0, 0);
        send(KIND_NEXT, 0, 0, 0, 0);
        send(KIND_RESETPB, 0, 0, 0, 0);
        send(4'd15, 127, 127, 255, 255);
        send(KIND_CLEAR, 0, 0, 0, 0);

        random_phase(430);
        drain();
        tx_idle = 49;
        rx_idle = 29;
        random_phase(430);
        drain();
        tx_idle = 0;
        rx_idle = 0;
        random_phase(430);
        drain();
        repeat (20) @(posedge aclk);

        if (sb.errors == 0) $display("PASS editable_repeat_command_queue");
        else $display("FAIL editable_repeat_command_queue");
        $finish;
    end

    // Timeout well beyond the slowest correct run.
    initial begin
        #40ms;
        $display("FAIL editable_repeat_command_queue");
        $finish;
    end
endmodule
